>>> design/iae_pkg.sv
// shared types, constants and command/status structs for the indexed array engine
package iae_pkg;

    localparam int DEPTH  = 32;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        REQ_APPEND  = 3'd0,
        REQ_INSERT  = 3'd1,
        REQ_REPLACE = 3'd2,
        REQ_GET     = 3'd3,
        REQ_DELETE  = 3'd4,
        REQ_FIND    = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic    load;
        logic    wr_word;
        logic    rd;
        logic    wr_shift;
        logic    ptr_init;
        logic    ptr_step;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_load;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        t_status    chk;
        logic [2:0] req;
        logic       more;
        logic       match;
        logic       out_busy;
    } t_dp_stat;

endpackage

>>> design/iae_ctrl.sv
// controller state machine: sequences checks, shift loops and search loops
module iae_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  iae_pkg::t_dp_stat i_stat,
    output iae_pkg::t_dp_cmd  o_cmd
);
    import iae_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_LOOP,
        S_STEP,
        S_FINISH
    } t_state;

    t_state  r_state, n_state;
    t_status r_code, n_code;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.code = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_code  = i_stat.chk;
                n_state = S_FINISH;
                if (i_stat.chk == ST_OK) begin
                    case (i_stat.req)
                        REQ_APPEND: begin
                            o_cmd.wr_word = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                        REQ_REPLACE: o_cmd.wr_word = 1'b1;
                        REQ_GET:     o_cmd.rd      = 1'b1;
                        REQ_INSERT, REQ_DELETE, REQ_FIND: begin
                            o_cmd.ptr_init = 1'b1;
                            n_state        = S_LOOP;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOP: begin
                if (i_stat.more) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_STEP;
                end else begin
                    n_state = S_FINISH;
                    case (i_stat.req)
                        REQ_INSERT: begin
                            o_cmd.wr_word = 1'b1;
                            o_cmd.cnt_inc = 1'b1;
                        end
                        REQ_DELETE: o_cmd.cnt_dec = 1'b1;
                        REQ_FIND:   n_code = ST_NOTFOUND;
                        default: ;
                    endcase
                end
            end
            S_STEP: begin
                if (i_stat.req == REQ_FIND && i_stat.match) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.wr_shift = (i_stat.req != REQ_FIND);
                    o_cmd.ptr_step = 1'b1;
                    n_state        = S_LOOP;
                end
            end
            S_FINISH: begin
                // hold the result until the output register can take it
                if (!i_stat.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

endmodule

>>> design/iae_datapath.sv
// datapath: entry memory, length count, scan pointer and result register
module iae_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [2:0]                    i_req_type,
    input  logic signed [31:0]            i_value,
    input  logic [5:0]                    i_index,
    input  iae_pkg::t_dp_cmd              i_cmd,
    output iae_pkg::t_dp_stat             o_stat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic signed [31:0]            o_read_value,
    output logic [4:0]                    o_found_index,
    output logic [5:0]                    o_length
);
    import iae_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    logic [2:0]        r_req;
    logic [DATA_W-1:0] r_word;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_ptr;

    logic              r_out_valid;
    t_status           r_status;
    logic [DATA_W-1:0] r_read_value;
    logic [ADDR_W-1:0] r_found;
    logic [CNT_W-1:0]  r_length;

    t_status           chk;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              we;
    logic [ADDR_W-1:0] raddr;
    logic [CNT_W:0]    ptr_inc;

    assign ptr_inc = {1'b0, r_ptr} + 1'b1;

    // range check comes before the full check
    always_comb begin
        chk = ST_OK;
        case (r_req)
            REQ_APPEND: if (r_count >= CNT_W'(DEPTH)) chk = ST_FULL;
            REQ_INSERT: begin
                if (r_idx > r_count)                chk = ST_RANGE;
                else if (r_count >= CNT_W'(DEPTH))  chk = ST_FULL;
            end
            REQ_REPLACE, REQ_GET, REQ_DELETE: if (r_idx >= r_count) chk = ST_RANGE;
            default: ;
        endcase
    end

    always_comb begin
        o_stat          = '0;
        o_stat.chk      = chk;
        o_stat.req      = r_req;
        o_stat.match    = (r_rdata == r_word);
        o_stat.out_busy = r_out_valid && !i_ready;
        case (r_req)
            REQ_INSERT: o_stat.more = (r_ptr > r_idx);
            REQ_DELETE: o_stat.more = (ptr_inc < {1'b0, r_count});
            REQ_FIND:   o_stat.more = (r_ptr < r_count);
            default:    o_stat.more = 1'b0;
        endcase
    end

    // write port: new word at the end or at the index, or a shifted entry at the pointer
    always_comb begin
        we    = i_cmd.wr_word || i_cmd.wr_shift;
        wdata = i_cmd.wr_shift ? r_rdata : r_word;
        if (i_cmd.wr_shift)
            waddr = r_ptr[ADDR_W-1:0];
        else if (r_req == REQ_APPEND)
            waddr = r_count[ADDR_W-1:0];
        else
            waddr = r_idx[ADDR_W-1:0];
    end

    // read port: index for get, neighbor for shifts, pointer for search
    always_comb begin
        case (r_req)
            REQ_INSERT: raddr = ADDR_W'(r_ptr - 1'b1);
            REQ_DELETE: raddr = ptr_inc[ADDR_W-1:0];
            REQ_FIND:   raddr = r_ptr[ADDR_W-1:0];
            default:    raddr = r_idx[ADDR_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we)
            r_mem[waddr] <= wdata;
        if (i_cmd.rd)
            r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_word <= i_value[DATA_W-1:0];
            r_idx  <= i_index;
        end
        if (i_cmd.ptr_init) begin
            case (r_req)
                REQ_INSERT: r_ptr <= r_count;
                REQ_DELETE: r_ptr <= r_idx;
                default:    r_ptr <= '0;
            endcase
        end else if (i_cmd.ptr_step) begin
            if (r_req == REQ_INSERT)
                r_ptr <= r_ptr - 1'b1;
            else
                r_ptr <= ptr_inc[CNT_W-1:0];
        end
        if (i_cmd.res_load) begin
            r_status     <= i_cmd.code;
            r_length     <= r_count;
            r_read_value <= (r_req == REQ_GET && i_cmd.code == ST_OK) ? r_rdata : '0;
            r_found      <= (r_req == REQ_FIND && i_cmd.code == ST_OK) ?
                            r_ptr[ADDR_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc)
                r_count <= r_count + 1'b1;
            else if (i_cmd.cnt_dec)
                r_count <= r_count - 1'b1;
            if (i_cmd.res_load)
                r_out_valid <= 1'b1;
            else if (i_ready)
                r_out_valid <= 1'b0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_found_index = r_found;
    assign o_length      = r_length;

endmodule

>>> design/indexed_array_engine_core.sv
// top level of the indexed array engine: controller plus datapath
// one word at a time; append, replace, get, unused codes and refused words pass through a check
// state and a finish state after acceptance; insert, delete and find also run a loop of a read
// state and a step state for each entry moved or compared, and find stops at the first match
// the entry memory has one read and one write port, so each step of a shift or search reads an
// entry, then writes or compares it; the next word is taken once the result is registered
// synchronous active-low reset clears the length and the output valid; entries are not cleared
module indexed_array_engine_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_value,
    input  logic [5:0]         i_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_read_value,
    output logic [4:0]         o_found_index,
    output logic [5:0]         o_length
);
    import iae_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    iae_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    iae_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_index       (i_index),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_found_index (o_found_index),
        .o_length      (o_length)
    );

    // one word in flight: no new word right after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("word accepted while another is in flight");

    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_length <= 6'(DEPTH)))
        else $error("reported length exceeds depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_read_value == '0 && o_found_index == '0))
        else $error("failed request reports nonzero data");

    // a result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !cmd.res_load)
        else $error("pending result overwritten");

endmodule

>>> test/array_result_checker.sv
`timescale 1ns / 100ps
// result checker for the indexed array engine: tracks the array, predicts and compares every result
module array_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  logic [2:0]         i_req_type,
    input  logic signed [31:0] i_req_value,
    input  logic [5:0]         i_req_index,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [1:0]         i_res_status,
    input  logic signed [31:0] i_res_read_value,
    input  logic [4:0]         i_res_found_index,
    input  logic [5:0]         i_res_length,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_stored_len
);
    import iae_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [31:0] read_value;
        logic [4:0]  found_index;
        logic [5:0]  length;
    } t_array_result;

    logic [31:0]   entries [DEPTH];
    int            stored_len = 0;
    int            pending = 0;
    int            fail_count = 0;
    t_array_result expected_results [$];

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_stored_len = stored_len;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0d ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // updates the array copy and works out the answer to one request word
    task automatic apply_request(input logic [2:0] code, input logic [31:0] word,
                                 input logic [5:0] pos, output t_array_result res);
        int k;
        res.status      = ST_OK;
        res.read_value  = '0;
        res.found_index = '0;
        case (code)
            REQ_APPEND: begin
                if (stored_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    entries[stored_len] = word;
                    stored_len++;
                end
            end
            REQ_INSERT: begin
                // range is checked ahead of the full condition
                if (pos > stored_len) begin
                    res.status = ST_RANGE;
                end else if (stored_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (k = stored_len; k > pos; k--)
                        entries[k] = entries[k - 1];
                    entries[pos] = word;
                    stored_len++;
                end
            end
            REQ_REPLACE: begin
                if (pos >= stored_len) res.status = ST_RANGE;
                else entries[pos] = word;
            end
            REQ_GET: begin
                if (pos >= stored_len) res.status = ST_RANGE;
                else res.read_value = entries[pos];
            end
            REQ_DELETE: begin
                if (pos >= stored_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (k = pos; k + 1 < stored_len; k++)
                        entries[k] = entries[k + 1];
                    stored_len--;
                end
            end
            REQ_FIND: begin
                res.status = ST_NOTFOUND;
                for (k = 0; k < stored_len && res.status == ST_NOTFOUND; k++) begin
                    if (entries[k] == word) begin
                        res.status      = ST_OK;
                        res.found_index = 5'(k);
                    end
                end
            end
            default: begin
            end
        endcase
        res.length = 6'(stored_len);
    endtask

    always @(posedge i_clk) begin : watch
        t_array_result want;
        if (!i_rst_n) begin
            stored_len = 0;
            pending    = 0;
            expected_results.delete();
        end else begin
            // results are taken first: a word accepted on this edge cannot answer yet
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unrequested result", 32'(i_res_status), '0);
                end else begin
                    want = expected_results.pop_front();
                    pending--;
                    if (i_res_status !== want.status)
                        report_mismatch("status", 32'(i_res_status), 32'(want.status));
                    if (i_res_read_value !== want.read_value)
                        report_mismatch("read_value", i_res_read_value, want.read_value);
                    if (i_res_found_index !== want.found_index)
                        report_mismatch("found_index", 32'(i_res_found_index),
                                        32'(want.found_index));
                    if (i_res_length !== want.length)
                        report_mismatch("length", 32'(i_res_length), 32'(want.length));
                end
            end
            if (i_req_valid && i_req_ready) begin
                apply_request(i_req_type, i_req_value, i_req_index, want);
                expected_results.push_back(want);
                pending++;
            end
        end
    end

endmodule

>>> test/indexed_array_engine_core_test.sv
`timescale 1ns / 100ps
// top of the indexed array engine testbench: clock, reset, request words and verdict
module indexed_array_engine_core_test;
    import iae_pkg::*;

    // request codes the block leaves unused
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;
    localparam int         DRAIN_CYCLES = 100;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic [2:0]         req_type = REQ_APPEND;
    logic signed [31:0] req_value = '0;
    logic [5:0]         req_index = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic [1:0]         res_status;
    logic signed [31:0] res_read_value;
    logic [4:0]         res_found_index;
    logic [5:0]         res_length;
    logic               steady = 1'b0;
    int                 fail_count;
    int                 pending;
    int                 stored_len;

    indexed_array_engine_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (req_valid),
        .o_ready       (req_ready),
        .i_req_type    (req_type),
        .i_value       (req_value),
        .i_index       (req_index),
        .o_valid       (res_valid),
        .i_ready       (res_ready),
        .o_status      (res_status),
        .o_read_value  (res_read_value),
        .o_found_index (res_found_index),
        .o_length      (res_length)
    );

    array_result_checker checker_inst (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_req_valid       (req_valid),
        .i_req_ready       (req_ready),
        .i_req_type        (req_type),
        .i_req_value       (req_value),
        .i_req_index       (req_index),
        .i_res_valid       (res_valid),
        .i_res_ready       (res_ready),
        .i_res_status      (res_status),
        .i_res_read_value  (res_read_value),
        .i_res_found_index (res_found_index),
        .i_res_length      (res_length),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_stored_len      (stored_len)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #10ms;
        $display("** indexed_array_engine_core: FAILED **");
        $finish;
    end

    always @(negedge clk) begin
        res_ready <= steady || ($urandom_range(99) >= 34);
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [2:0] code, input logic [31:0] word,
                             input logic [5:0] pos);
        while (!steady && $urandom_range(99) < 34) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= code;
        req_value <= word;
        req_index <= pos;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    initial begin : stimulus
        int          n;
        int          len;
        int          roll;
        bit          filling;
        logic [2:0]  code;
        logic [31:0] word;
        logic [5:0]  pos;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty array: get, delete, replace and insert past the end are out of range
        send_word(REQ_GET,     32'h0, 6'd0);
        send_word(REQ_DELETE,  32'h0, 6'd0);
        send_word(REQ_REPLACE, 32'h0, 6'd0);
        send_word(REQ_INSERT,  32'h1, 6'd1);
        send_word(REQ_FIND,    32'h0, 6'd0);
        send_word(REQ_INSERT,  32'h8000_0000, 6'd0);
        send_word(REQ_APPEND,  32'h7fff_ffff, 6'd63);
        send_word(REQ_APPEND,  32'hffff_ffff, 6'd0);
        send_word(REQ_APPEND,  32'h0, 6'd0);
        send_word(REQ_GET,     32'hffff_ffff, 6'd0);
        send_word(REQ_REPLACE, 32'h5555_5555, 6'd3);
        send_word(REQ_FIND,    32'h5555_5555, 6'd0);
        send_word(REQ_FIND,    32'h0, 6'd0);
        // insert at the current length lands at the end
        send_word(REQ_INSERT,  32'haaaa_aaaa, 6'd4);
        send_word(REQ_INSERT,  32'h1234_5678, 6'd6);
        send_word(REQ_DELETE,  32'h0, 6'd0);
        send_word(REQ_GET,     32'h0, 6'd3);
        send_word(REQ_GET,     32'h0, 6'd4);
        send_word(REQ_GET,     32'h0, 6'd32);
        send_word(REQ_SPARE_6, 32'hffff_ffff, 6'd63);
        send_word(REQ_SPARE_7, 32'h0, 6'd0);
        send_word(REQ_DELETE,  32'h0, 6'd3);
        send_word(REQ_FIND,    32'hffff_ffff, 6'd0);
        wait_drained();

        filling = 1'b1;
        for (n = 0; n < 480; n++) begin
            steady = (n >= 120 && n < 220);
            if (n == 300) wait_drained();
            len = stored_len;
            if (len == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
            else if (len == 0) filling = 1'b1;
            else if ($urandom_range(49) == 0) filling = !filling;

            roll = $urandom_range(99);
            if (roll >= 98) code = roll[0] ? REQ_SPARE_7 : REQ_SPARE_6;
            else if (filling) begin
                if (roll < 35) code = REQ_APPEND;
                else if (roll < 60) code = REQ_INSERT;
                else if (roll < 70) code = REQ_REPLACE;
                else if (roll < 80) code = REQ_GET;
                else if (roll < 88) code = REQ_DELETE;
                else code = REQ_FIND;
            end else begin
                if (roll < 8) code = REQ_APPEND;
                else if (roll < 16) code = REQ_INSERT;
                else if (roll < 26) code = REQ_REPLACE;
                else if (roll < 38) code = REQ_GET;
                else if (roll < 83) code = REQ_DELETE;
                else code = REQ_FIND;
            end

            // a few recurring words so that finds often hit
            if ($urandom_range(1) == 0) begin
                case ($urandom_range(5))
                    0: word = 32'h0;
                    1: word = 32'hffff_ffff;
                    2: word = 32'h8000_0000;
                    3: word = 32'h7fff_ffff;
                    4: word = 32'h1;
                    default: word = 32'h1234_5678;
                endcase
            end else begin
                word = $urandom;
            end

            if ($urandom_range(4) == 0) pos = 6'($urandom_range(32));
            else if (code == REQ_INSERT) pos = 6'($urandom_range(len));
            else pos = (len > 0) ? 6'($urandom_range(len - 1)) : 6'd0;

            send_word(code, word, pos);
        end
        steady = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("** indexed_array_engine_core: PASSED **");
        end else begin
            $display("** indexed_array_engine_core: FAILED **");
        end
        $finish;
    end

endmodule

>>> indexed_array_engine_core.f
design/iae_pkg.sv
design/iae_ctrl.sv
design/iae_datapath.sv
design/indexed_array_engine_core.sv
test/array_result_checker.sv
test/indexed_array_engine_core_test.sv
